[rtl/mbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_pkg - shared definitions for the mailbox ring
// Command and status codes, build defaults and the per-transaction result
// record passed from the control block to the output stage.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CFG_W         = 5;
  localparam int unsigned CNT_OUT_W     = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_URGENT = 2'd1,
    CMD_RECV   = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic                 handed;
    logic                 from_ram;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

[rtl/mbr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_if - command and response channels of the mailbox ring
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface mbr_cmd_if #(
  parameter int unsigned WORD_BITS = mbr_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [WORD_BITS-1:0] message_in;
  logic                 waiter_present;

  modport source (output valid, command, message_in, waiter_present, input ready);
  modport sink   (input valid, command, message_in, waiter_present, output ready);
endinterface

interface mbr_rsp_if #(
  parameter int unsigned WORD_BITS = mbr_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [WORD_BITS-1:0] message_out;
  logic                 handed_to_waiter;
  logic [4:0]           stored_count;

  modport source (output valid, status, message_out, handed_to_waiter, stored_count,
                  input ready);
  modport sink   (input valid, status, message_out, handed_to_waiter, stored_count,
                  output ready);
endinterface
`default_nettype wire

[rtl/mbr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/mbr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_ctrl - pointer, count and capacity control of the mailbox ring
// Decodes one command per transaction, steers the slot RAM and updates the
// read pointer, write pointer and message count.
// ----------------------------------------------------------------------------
module mbr_ctrl #(
  parameter int unsigned DEPTH     = mbr_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = mbr_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mbr_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                       take_i,
  input  wire logic [1:0]                 command_i,
  input  wire logic [WORD_BITS-1:0]       message_i,
  input  wire logic                       waiter_i,
  output logic                            ram_we_o,
  output logic      [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output logic      [WORD_BITS-1:0]       ram_wdata_o,
  output logic                            ram_re_o,
  output logic      [$clog2(DEPTH)-1:0]   ram_raddr_o,
  output mbr_pkg::res_t                   res_o
);
  import mbr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cap_q;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] rp_inc, wp_inc;
  logic [PTR_W-1:0] rp_adv, wp_adv, rp_dec;
  logic             we;
  status_e          status;
  logic             handed;
  logic             from_ram;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (EXT_W'(cap_q) > EXT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  // Step a pointer, wrapping at capacity
  assign rp_inc = CNT_W'(rp_q) + CNT_W'(1);
  assign wp_inc = CNT_W'(wp_q) + CNT_W'(1);
  assign rp_adv = (rp_inc >= cap_eff) ? '0 : PTR_W'(rp_inc);
  assign wp_adv = (wp_inc >= cap_eff) ? '0 : PTR_W'(wp_inc);
  assign rp_dec = (rp_q == '0) ? PTR_W'(cap_eff - CNT_W'(1)) : rp_q - PTR_W'(1);

  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    we          = 1'b0;
    ram_waddr_o = wp_q;
    status      = ST_OK;
    handed      = 1'b0;
    from_ram    = 1'b0;
    case (cmd_e'(command_i))
      CMD_SEND, CMD_URGENT: begin
        if (waiter_i) begin
          handed = 1'b1;
        end else if (cnt_q >= cap_eff) begin
          status = ST_FULL;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
          if (cmd_e'(command_i) == CMD_URGENT) begin
            rp_d        = rp_dec;
            ram_waddr_o = rp_dec;
          end else begin
            wp_d = wp_adv;
          end
        end
      end
      CMD_RECV: begin
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else begin
          from_ram = 1'b1;
          rp_d     = rp_adv;
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      CMD_FLUSH: begin
        if (!waiter_i) begin
          rp_d  = '0;
          wp_d  = '0;
          cnt_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else if (take_i) begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  assign ram_we_o       = take_i & we;
  assign ram_wdata_o    = message_i;
  assign ram_re_o       = take_i;
  assign ram_raddr_o    = rp_q;
  assign res_o.status   = status;
  assign res_o.handed   = handed;
  assign res_o.from_ram = from_ram;
  assign res_o.count    = CNT_OUT_W'(cnt_d);

endmodule
`default_nettype wire

[rtl/mailbox_ring_with_urgent_insert.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mailbox_ring_with_urgent_insert - hardware mailbox on a ring of slots
// Normal sends append, urgent sends insert ahead of the next receive, sends
// with a waiting receiver bypass the store; a flush without one clears the ring.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  cmd_i     in   valid/ready    command, message_in, waiter_present
//  rsp_o     out  valid/ready    status, message_out, handed_to_waiter,
//                                stored_count
//  cfg       in   cfg_we_i       cfg_wdata_i = capacity (5 bits)
//
//  One transaction per cycle while rsp_o is not stalled. Its response is
//  valid the cycle after it is taken, set by the registered read port of the
//  slot RAM. Reset clears pointers and count and sets capacity to 16; the
//  slot RAM is not cleared and needs no clearing pass, so commands are taken
//  at once. A stalled response holds the output register and the RAM read
//  data; cmd_i is then held off until the response is taken.
//
module mailbox_ring_with_urgent_insert #(
  parameter int unsigned DEPTH     = mbr_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = mbr_pkg::WORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [mbr_pkg::CFG_W-1:0] cfg_wdata_i,
  mbr_cmd_if.sink                        cmd_i,
  mbr_rsp_if.source                      rsp_o
);
  import mbr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic                 take;
  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  res_t                 res;

  logic                 valid_q;
  res_t                 res_q;
  logic [WORD_BITS-1:0] msg_q;

  // Take a new transaction whenever the output register is free or draining
  assign cmd_i.ready = !valid_q || rsp_o.ready;
  assign take        = cmd_i.valid && cmd_i.ready;

  mbr_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .command_i   (cmd_i.command),
    .message_i   (cmd_i.message_in),
    .waiter_i    (cmd_i.waiter_present),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_o       (res)
  );

  // Slot store; read data follows the read pointer of the taken transaction
  mbr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: advance on take, drop once the response is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the handed-off word; zero it for every other outcome
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
      msg_q <= res.handed ? cmd_i.message_in : '0;
    end
  end

  assign rsp_o.valid            = valid_q;
  assign rsp_o.status           = res_q.status;
  assign rsp_o.message_out      = res_q.from_ram ? ram_rdata : msg_q;
  assign rsp_o.handed_to_waiter = res_q.handed;
  assign rsp_o.stored_count     = res_q.count;

  // A handoff never reports full or empty
  a_handoff_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.handed_to_waiter |-> rsp_o.status == ST_OK)
    else $error("handoff with non-ok status");

  // An empty receive leaves nothing stored and carries no word
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_EMPTY |->
      rsp_o.stored_count == '0 && rsp_o.message_out == '0)
    else $error("empty response with data or count");

  // A flush without a waiter reports an empty ring in the next response
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd_i.command == CMD_FLUSH && !cmd_i.waiter_present |=>
      rsp_o.valid && rsp_o.stored_count == '0)
    else $error("flush did not clear count");

  // The slot RAM is written only by a taken send
  a_write_on_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> take && !cmd_i.waiter_present &&
      (cmd_i.command == CMD_SEND || cmd_i.command == CMD_URGENT))
    else $error("slot write outside a send");

endmodule
`default_nettype wire

[tb/sv/tb_mbr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mbr_checker - reply predictor and scoreboard for the mailbox ring
// Watches the command and reply channels and the capacity write port, keeps
// its own copy of the ring and works out the reply to each command. Each reply
// is then checked field by field against the oldest one still awaited.
// ----------------------------------------------------------------------------
module tb_mbr_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mbr_pkg::CFG_W-1:0] cfg_wdata_i,
  mbr_cmd_if                        cmd_mon,
  mbr_rsp_if                        rsp_mon,
  output int                        pending_o,
  output int                        mismatches_o
);
  import mbr_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [31:0]          word;
    logic                 handed;
    logic [CNT_OUT_W-1:0] held;
  } reply_t;

  logic [31:0]          ring_words [DEPTH_DEF];
  logic [3:0]           head_slot;
  logic [3:0]           tail_slot;
  logic [CNT_OUT_W-1:0] held_msgs;
  logic [CFG_W-1:0]     capacity_q;
  reply_t               awaited_replies [$];
  int                   mismatch_total;

  assign mismatches_o = mismatch_total;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_total++;
    $display("[%0t] mailbox reply %s: got 0x%0h, expected 0x%0h",
             $realtime, what, got, want);
  endtask

  // Capacity 0 behaves as 1, anything past the built depth as the depth.
  function automatic logic [4:0] ring_limit();
    if (capacity_q == '0) return 5'd1;
    if (capacity_q > DEPTH_DEF) return 5'(DEPTH_DEF);
    return capacity_q;
  endfunction

  // Wrap to slot 0 on reaching the limit or beyond it.
  function automatic logic [3:0] next_slot(input logic [3:0] slot, input logic [4:0] lim);
    logic [4:0] n;
    n = {1'b0, slot} + 5'd1;
    return (n >= lim) ? 4'd0 : n[3:0];
  endfunction

  task automatic predict_reply(input cmd_e op, input logic [31:0] word,
                               input logic waiter, output reply_t r);
    logic [4:0] lim;
    lim = ring_limit();
    r = '{status: ST_OK, word: '0, handed: 1'b0, held: '0};
    case (op)
      CMD_SEND, CMD_URGENT: begin
        if (waiter) begin
          r.word   = word;
          r.handed = 1'b1;
        end else if (held_msgs >= lim) begin
          r.status = ST_FULL;
        end else begin
          if (op == CMD_URGENT) begin
            head_slot = (head_slot == 4'd0) ? 4'(lim - 5'd1) : head_slot - 4'd1;
            ring_words[head_slot] = word;
          end else begin
            ring_words[tail_slot] = word;
            tail_slot = next_slot(tail_slot, lim);
          end
          held_msgs++;
        end
      end
      CMD_RECV: begin
        if (held_msgs == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word    = ring_words[head_slot];
          head_slot = next_slot(head_slot, lim);
          held_msgs--;
        end
      end
      default: begin
        if (!waiter) begin
          held_msgs = '0;
          head_slot = '0;
          tail_slot = '0;
        end
      end
    endcase
    r.held = held_msgs;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t fresh;
    if (!rst_ni) begin
      head_slot  = '0;
      tail_slot  = '0;
      held_msgs  = '0;
      capacity_q = CAP_RESET;
      awaited_replies.delete();
      pending_o <= 0;
    end else begin
      // Check replies first: a reply never belongs to a command taken at the same edge.
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          flag_mismatch("with none awaited, message_out", rsp_mon.message_out, '0);
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_mon.status !== want.status)
            flag_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
          if (rsp_mon.message_out !== want.word)
            flag_mismatch("message_out", rsp_mon.message_out, want.word);
          if (rsp_mon.handed_to_waiter !== want.handed)
            flag_mismatch("handed_to_waiter", 32'(rsp_mon.handed_to_waiter),
                          32'(want.handed));
          if (rsp_mon.stored_count !== want.held)
            flag_mismatch("stored_count", 32'(rsp_mon.stored_count), 32'(want.held));
        end
      end
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (cmd_mon.valid && cmd_mon.ready) begin
        predict_reply(cmd_e'(cmd_mon.command), cmd_mon.message_in,
                      cmd_mon.waiter_present, fresh);
        awaited_replies.push_back(fresh);
      end
      pending_o <= awaited_replies.size();
    end
  end

endmodule

[tb/sv/tb_mailbox_ring_with_urgent_insert.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mailbox_ring_with_urgent_insert - testbench top for the mailbox ring
// Drives commands and reply back-pressure, rewrites the capacity between
// phases and leaves all prediction and checking to tb_mbr_checker. The run
// opens with directed commands and continues with biased random traffic.
// ----------------------------------------------------------------------------
module tb_mailbox_ring_with_urgent_insert;
  import mbr_pkg::*;

  // Cycles without a single transaction on either channel before giving up.
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_PHASES  = 9;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  int send_gap_pct;
  int ready_gap_pct;
  int pending;
  int mismatches;
  int quiet_cycles;

  mbr_cmd_if cmd_ch ();
  mbr_rsp_if rsp_ch ();

  mailbox_ring_with_urgent_insert i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_ch),
    .rsp_o       (rsp_ch)
  );

  tb_mbr_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_mon      (cmd_ch),
    .rsp_mon      (rsp_ch),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reply back-pressure: drop ready at random, at the rate set by the current phase.
  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= ready_gap_pct);
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_mailbox_ring_with_urgent_insert NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command and hold it until the block takes it. Valid is only
  // lowered inside an idle gap, so back-to-back commands keep it high without
  // a second assignment in the same step.
  task automatic offer(input cmd_e op, input logic [31:0] word, input logic waiter);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.command        <= op;
    cmd_ch.message_in     <= word;
    cmd_ch.waiter_present <= waiter;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  // Stop offering and wait until every reply has been taken. Each command
  // yields exactly one reply, so the block is idle once none is awaited.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random command. send_pct steers the ring towards full (high) or
  // empty (low) so that both ends are reached at every capacity; a small
  // share of flushes and waiting receivers keeps the odd cases in the mix.
  task automatic random_item(input int send_pct);
    int   r;
    cmd_e op;
    r = $urandom_range(99);
    if (r < 4) begin
      op = CMD_FLUSH;
    end else if (r < 4 + send_pct) begin
      op = ($urandom_range(99) < 40) ? CMD_URGENT : CMD_SEND;
    end else begin
      op = CMD_RECV;
    end
    offer(op, $urandom, ($urandom_range(99) < 12));
  endtask

  initial begin
    logic [CFG_W-1:0] caps [NUM_PHASES];
    int               left;
    int               chunk;
    bit               filling;

    // Every input known from time zero.
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.command        = CMD_SEND;
    cmd_ch.message_in     = '0;
    cmd_ch.waiter_present = 1'b0;
    rsp_ch.ready          = 1'b0;
    quiet_cycles          = 0;
    send_gap_pct          = 38;
    ready_gap_pct         = 75;

    // Zero, all ones, one, the built depth and just past it, then a few in between.
    caps[0] = 5'd1;
    caps[1] = 5'd0;
    caps[2] = 5'd31;
    caps[3] = 5'd5;
    caps[4] = 5'd16;
    caps[5] = 5'd17;
    caps[6] = 5'd2;
    caps[7] = 5'($urandom_range(3, 15));
    caps[8] = 5'd12;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset capacity of 16.
    // Receive from an empty ring.
    offer(CMD_RECV, 32'hFFFF_FFFF, 1'b0);
    // Normal send of all zeros, then an urgent send of all ones that must wrap
    // the read slot from 0 back to the top of the ring.
    offer(CMD_SEND, 32'h0000_0000, 1'b0);
    offer(CMD_URGENT, 32'hFFFF_FFFF, 1'b0);
    // Fill the rest. Every slot has then been written once, so later capacity
    // changes with messages held can never read a slot that holds nothing.
    for (int k = 0; k < 14; k++) offer(CMD_SEND, $urandom, 1'b0);
    // Both kinds of send against a full ring.
    offer(CMD_SEND, $urandom, 1'b0);
    offer(CMD_URGENT, $urandom, 1'b0);
    // Hand-off to a waiting receiver bypasses the store, even when full.
    offer(CMD_SEND, 32'h0000_0000, 1'b1);
    offer(CMD_URGENT, 32'hFFFF_FFFF, 1'b1);
    // A receive ignores the waiter flag; this one also wraps the read slot.
    offer(CMD_RECV, $urandom, 1'b1);
    // Flush with a waiter leaves everything alone; without one it empties.
    offer(CMD_FLUSH, $urandom, 1'b1);
    offer(CMD_FLUSH, $urandom, 1'b0);
    offer(CMD_RECV, $urandom, 1'b0);

    // Random phases. The capacity changes while the block is idle but often
    // with messages held, so lowered capacities leave pointers past the limit.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES / 3) begin
        send_gap_pct  = 75;
        ready_gap_pct = 38;
      end else if (ph == 2 * NUM_PHASES / 3) begin
        send_gap_pct  = 0;
        ready_gap_pct = 0;
      end
      write_capacity(caps[ph]);
      left    = PHASE_ITEMS;
      filling = ($urandom_range(1) == 1);
      while (left > 0) begin
        chunk = $urandom_range(8, 40);
        for (int k = 0; k < chunk && left > 0; k++) begin
          random_item(filling ? 70 : 25);
          left--;
        end
        filling = !filling;
      end
    end

    // Drain, then allow a few cycles for any stray reply to show up.
    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_mailbox_ring_with_urgent_insert OK");
    end else begin
      $display("tb_mailbox_ring_with_urgent_insert NOT OK");
    end
    $finish;
  end

endmodule
